// File: rtl/ssm_pkg.sv
// shared types and constants for the sorted stream merge core
// no dependencies
`default_nettype none
package ssm_pkg;
  localparam int unsigned ID_W     = 3;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned HREAD_W  = 17;
  localparam int unsigned READS_W  = 20;
  localparam int unsigned METH_W   = 19;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned RANK_W   = 10;

  typedef enum logic [STAT_W-1:0] {
    ST_SITE   = 2'd0,
    ST_END    = 2'd1,
    ST_UNSORT = 2'd2
  } status_t;

  // item passed from front to back
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic             is_end;
    logic             new_chrom;
    logic [RANK_W-1:0] rank;
    logic [POS_W-1:0] step;
    logic [CNT_W-1:0] meth;
    logic [CNT_W-1:0] unmeth;
  } item_t;

  // result record
  typedef struct packed {
    status_t           status;
    logic [RANK_W-1:0] chrom;
    logic [POS_W-1:0]  pos;
    logic [READS_W-1:0] reads;
    logic [METH_W-1:0] meth;
    logic [MASK_W-1:0] mask;
    logic [ID_W-1:0]   bad;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SUM,
    BK_EMIT
  } bk_state_t;
endpackage
`default_nettype wire

// File: rtl/sorted_stream_merge_count_sum_core.sv
// top level of the sorted stream merge core: front queue, back engine, result queue
// depends on ssm_pkg, ssm_fifo, ssm_back
//
// channel  | handshake        | payload
// input    | push / full      | stream_id .. unmeth_count
// result   | pop / empty      | status .. bad_stream
// config   | cfg_we           | cfg_data (active_streams)
//
// a refill is handled in the back engine's idle state; the refill that completes a set
// adds a scan pass and a sum pass over MAX_STREAMS heads, then an emit state.
// the two-entry front queue takes items while the back engine works.
// reset (rst, synchronous) sets 8 active streams, all pending, no heads.
// a full result queue stalls the back engine, which then stalls the input.
`default_nettype none
module sorted_stream_merge_count_sum_core #(
  parameter int unsigned MAX_STREAMS = 8,
  parameter int unsigned CHROM_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  stream_id,
  input  wire logic        is_end,
  input  wire logic        new_chrom,
  input  wire logic [9:0]  chrom_rank,
  input  wire logic [31:0] pos_delta,
  input  wire logic [15:0] meth_count,
  input  wire logic [15:0] unmeth_count,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       status,
  output logic [9:0]       site_chrom,
  output logic [31:0]      site_pos,
  output logic [19:0]      total_reads,
  output logic [18:0]      total_meth,
  output logic [7:0]       stream_mask,
  output logic [2:0]       bad_stream
);
  import ssm_pkg::*;

  logic [CFG_W-1:0] active_streams;
  item_t in_item, q_item;
  result_t res, out_res;
  logic q_empty, q_pop, r_push, r_full;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) active_streams <= CFG_W'(8);
    else if (cfg_we) active_streams <= cfg_data;
  end

  assign in_item = '{id: stream_id, is_end: is_end, new_chrom: new_chrom,
                     rank: chrom_rank, step: pos_delta, meth: meth_count,
                     unmeth: unmeth_count};

  // front queue
  ssm_fifo #(.WIDTH($bits(item_t)), .DEPTH_LOG(1)) u_front (
    .clk(clk), .rst(rst), .wr(push), .wdata(in_item), .full(full),
    .rd(q_pop), .rdata(q_item), .empty(q_empty)
  );

  ssm_back #(.MAX_STREAMS(MAX_STREAMS), .CHROM_BITS(CHROM_BITS)) u_back (
    .clk(clk), .rst(rst), .active_streams(active_streams),
    .item(q_item), .item_empty(q_empty), .item_pop(q_pop),
    .res(res), .res_push(r_push), .res_full(r_full)
  );

  // result queue
  ssm_fifo #(.WIDTH($bits(result_t)), .DEPTH_LOG(1)) u_res (
    .clk(clk), .rst(rst), .wr(r_push), .wdata(res), .full(r_full),
    .rd(pop), .rdata(out_res), .empty(empty)
  );

  assign status      = out_res.status;
  assign site_chrom  = out_res.chrom;
  assign site_pos    = out_res.pos;
  assign total_reads = out_res.reads;
  assign total_meth  = out_res.meth;
  assign stream_mask = out_res.mask;
  assign bad_stream  = out_res.bad;
endmodule
`default_nettype wire

// File: rtl/ssm_fifo.sv
// small synchronous queue used between front and back and for results
// depends on nothing
`default_nettype none
module ssm_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH_LOG = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int unsigned DEPTH = 1 << DEPTH_LOG;
  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH_LOG:0] wp, rp;

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      if (wr && !full) wp <= wp + 1'b1;
      if (rd && !empty) rp <= rp + 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp[DEPTH_LOG-1:0]] <= wdata;
  end

  assign rdata = mem[rp[DEPTH_LOG-1:0]];
  assign empty = (wp == rp);
  assign full  = (wp[DEPTH_LOG] != rp[DEPTH_LOG]) &&
                 (wp[DEPTH_LOG-1:0] == rp[DEPTH_LOG-1:0]);
endmodule
`default_nettype wire

// File: rtl/ssm_back.sv
// back part: head table, refill check, scan for least head and summing
// depends on ssm_pkg
`default_nettype none
module ssm_back #(
  parameter int unsigned MAX_STREAMS = 8,
  parameter int unsigned CHROM_BITS = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [ssm_pkg::CFG_W-1:0] active_streams,
  input  wire ssm_pkg::item_t          item,
  input  wire logic                    item_empty,
  output logic                         item_pop,
  output ssm_pkg::result_t             res,
  output logic                         res_push,
  input  wire logic                    res_full
);
  import ssm_pkg::*;
  localparam int unsigned SW = $clog2(MAX_STREAMS);
  localparam int unsigned CW = $clog2(MAX_STREAMS + 1);

  logic [MAX_STREAMS-1:0] head_valid, pending, has_read;
  logic [CHROM_BITS-1:0]  head_chrom [MAX_STREAMS];
  logic [POS_W-1:0]       head_pos   [MAX_STREAMS];
  logic [CNT_W-1:0]       head_meth  [MAX_STREAMS];
  logic [HREAD_W-1:0]     head_reads [MAX_STREAMS];

  bk_state_t state, state_next;
  logic [CW-1:0] idx;
  logic          any;
  logic [CHROM_BITS-1:0] best_chrom;
  logic [POS_W-1:0]      best_pos;
  logic [READS_W:0]      sum_reads;
  logic [METH_W:0]       sum_meth;
  logic [MAX_STREAMS-1:0] mask;

  // effective stream count
  logic [CW-1:0] live;
  always_comb begin
    if (active_streams == '0) live = CW'(1);
    else if (32'(active_streams) > MAX_STREAMS) live = CW'(MAX_STREAMS);
    else live = CW'(active_streams);
  end

  // refill evaluation for the head item of the queue
  logic [SW-1:0]         iid;
  logic                  wanted, unsorted;
  logic [CHROM_BITS-1:0] n_chrom;
  logic [POS_W:0]        n_sum;
  logic [POS_W-1:0]      n_pos, base;
  logic [MAX_STREAMS-1:0] pend_after;
  always_comb begin
    iid = SW'(item.id);
    wanted = (32'(item.id) < 32'(live)) && pending[iid];
    n_chrom = item.new_chrom ? CHROM_BITS'(item.rank) : head_chrom[iid];
    base = item.new_chrom ? '0 : head_pos[iid];
    n_sum = {1'b0, base} + {1'b0, item.step};
    n_pos = n_sum[POS_W] ? '1 : n_sum[POS_W-1:0];
    unsorted = !item.is_end && has_read[iid] && (n_chrom == head_chrom[iid]) &&
               (n_pos <= head_pos[iid]);
    pend_after = pending;
    pend_after[iid] = 1'b0;
  end

  // any live stream still pending after this refill
  logic still_pend;
  always_comb begin
    still_pend = 1'b0;
    for (int i = 0; i < MAX_STREAMS; i++)
      if (i < 32'(live) && pend_after[i]) still_pend = 1'b1;
  end

  logic cur_v, cur_less, cur_eq;
  always_comb begin
    cur_v = (32'(idx) < 32'(live)) && head_valid[SW'(idx)];
    cur_less = (head_chrom[SW'(idx)] < best_chrom) ||
               (head_chrom[SW'(idx)] == best_chrom && head_pos[SW'(idx)] < best_pos);
    cur_eq = (head_chrom[SW'(idx)] == best_chrom) && (head_pos[SW'(idx)] == best_pos);
  end

  logic idle_take;
  assign idle_take = (state == BK_IDLE) && !item_empty && !res_full;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (idle_take && wanted && !unsorted && !still_pend) state_next = BK_SCAN;
      end
      BK_SCAN: begin
        if (32'(idx) == MAX_STREAMS - 1) state_next = BK_SUM;
      end
      BK_SUM: begin
        if (32'(idx) == MAX_STREAMS - 1) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (!res_full) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_pop = idle_take;
    res_push = 1'b0;
    res = '0;
    case (state)
      BK_IDLE: begin
        if (idle_take && wanted && unsorted) begin
          res_push = 1'b1;
          res.status = ST_UNSORT;
          res.bad = item.id;
        end
      end
      BK_EMIT: begin
        res_push = !res_full;
        if (!any) begin
          res.status = ST_END;
        end else begin
          res.status = ST_SITE;
          res.chrom = RANK_W'(best_chrom);
          res.pos = best_pos;
          res.reads = sum_reads[READS_W] ? '1 : sum_reads[READS_W-1:0];
          res.meth = sum_meth[METH_W] ? '1 : sum_meth[METH_W-1:0];
          res.mask = MASK_W'(mask);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  // head table and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      pending <= '1;
      has_read <= '0;
      idx <= '0;
      any <= 1'b0;
      for (int i = 0; i < MAX_STREAMS; i++) begin
        head_chrom[i] <= '0;
        head_pos[i] <= '0;
        head_meth[i] <= '0;
        head_reads[i] <= '0;
      end
    end else begin
      case (state)
        BK_IDLE: begin
          idx <= '0;
          any <= 1'b0;
          mask <= '0;
          sum_reads <= '0;
          sum_meth <= '0;
          if (idle_take && wanted && !unsorted) begin
            pending[iid] <= 1'b0;
            if (item.is_end) begin
              head_valid[iid] <= 1'b0;
            end else begin
              head_valid[iid] <= 1'b1;
              has_read[iid] <= 1'b1;
              head_chrom[iid] <= n_chrom;
              head_pos[iid] <= n_pos;
              head_meth[iid] <= item.meth;
              head_reads[iid] <= HREAD_W'(item.meth) + HREAD_W'(item.unmeth);
            end
          end
        end
        BK_SCAN: begin
          if (cur_v && (!any || cur_less)) begin
            best_chrom <= head_chrom[SW'(idx)];
            best_pos <= head_pos[SW'(idx)];
            any <= 1'b1;
          end
          idx <= (32'(idx) == MAX_STREAMS - 1) ? '0 : idx + 1'b1;
        end
        BK_SUM: begin
          if (any && cur_v && cur_eq) begin
            mask[SW'(idx)] <= 1'b1;
            pending[SW'(idx)] <= 1'b1;
            sum_reads <= sum_reads + (READS_W+1)'(head_reads[SW'(idx)]);
            sum_meth <= sum_meth + (METH_W+1)'(head_meth[SW'(idx)]);
          end
          if (32'(idx) != MAX_STREAMS - 1) idx <= idx + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: dv/tb_sorted_stream_merge_count_sum_core.sv
// testbench for sorted_stream_merge_count_sum_core: queue-fed driver, monitor, merge predictor
// depends on ssm_pkg and the rtl of the core
`timescale 1ns / 100ps
module tb_sorted_stream_merge_count_sum_core;
  import ssm_pkg::*;

  localparam int NSTR = 8;
  localparam int LIMIT = 400000;
  localparam int SETTLE = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_data = '0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0] status;
  logic [9:0] site_chrom;
  logic [31:0] site_pos;
  logic [19:0] total_reads;
  logic [18:0] total_meth;
  logic [7:0] stream_mask;
  logic [2:0] bad_stream;

  item_t drv_item = '0;
  item_t refill_q[$];
  result_t site_q[$];
  int in_flight = 0;
  int useful = 0;
  int send_gap = 0;
  int pop_gap = 0;
  bit quiet = 0;
  int errors = 0;
  int cycles = 0;

  // predictor state
  logic [3:0] m_active;
  bit m_valid[NSTR];
  bit m_pend[NSTR];
  bit m_seen[NSTR];
  logic [9:0] m_chrom[NSTR];
  logic [31:0] m_pos[NSTR];
  logic [15:0] m_meth[NSTR];
  logic [16:0] m_reads[NSTR];

  sorted_stream_merge_count_sum_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .push(push), .full(full),
    .stream_id(drv_item.id), .is_end(drv_item.is_end), .new_chrom(drv_item.new_chrom),
    .chrom_rank(drv_item.rank), .pos_delta(drv_item.step),
    .meth_count(drv_item.meth), .unmeth_count(drv_item.unmeth),
    .empty(empty), .pop(pop), .status(status), .site_chrom(site_chrom),
    .site_pos(site_pos), .total_reads(total_reads), .total_meth(total_meth),
    .stream_mask(stream_mask), .bad_stream(bad_stream)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_streams();
    if (m_active == 0) return 1;
    if (m_active > NSTR) return NSTR;
    return m_active;
  endfunction

  function automatic void merge_reset();
    m_active = 4'd8;
    for (int i = 0; i < NSTR; i++) begin
      m_valid[i] = 0; m_pend[i] = 1; m_seen[i] = 0;
      m_chrom[i] = '0; m_pos[i] = '0; m_meth[i] = '0; m_reads[i] = '0;
    end
  endfunction

  // 0 ignored, 1 taken without result, 2 taken with result in r
  function automatic int merge_refill(item_t it, output result_t r);
    int n;
    int id;
    int best;
    bit any;
    logic [9:0] ch;
    logic [32:0] ps;
    logic [20:0] rd;
    logic [19:0] mt;
    logic [7:0] mask;
    n = live_streams();
    id = it.id;
    r = '0;
    if (id >= n || !m_pend[id]) return 0;
    if (it.is_end) begin
      m_pend[id] = 0;
      m_valid[id] = 0;
    end else begin
      ch = it.new_chrom ? it.rank : m_chrom[id];
      ps = it.new_chrom ? 33'd0 : {1'b0, m_pos[id]};
      ps = ps + it.step;
      if (ps[32]) ps = 33'h0_FFFF_FFFF;
      // a site that does not move forward on the same chromosome
      if (m_seen[id] && ch == m_chrom[id] && ps[31:0] <= m_pos[id]) begin
        r.status = ST_UNSORT;
        r.bad = id[2:0];
        return 2;
      end
      m_pend[id] = 0; m_valid[id] = 1; m_seen[id] = 1;
      m_chrom[id] = ch; m_pos[id] = ps[31:0];
      m_meth[id] = it.meth;
      m_reads[id] = {1'b0, it.meth} + {1'b0, it.unmeth};
    end
    for (int i = 0; i < n; i++)
      if (m_pend[i]) return 1;
    any = 0;
    best = 0;
    for (int i = 0; i < n; i++) begin
      if (m_valid[i]) begin
        if (!any || m_chrom[i] < m_chrom[best] ||
            (m_chrom[i] == m_chrom[best] && m_pos[i] < m_pos[best])) best = i;
        any = 1;
      end
    end
    if (!any) begin
      r.status = ST_END;
      return 2;
    end
    rd = '0; mt = '0; mask = '0;
    for (int i = 0; i < n; i++) begin
      if (m_valid[i] && m_chrom[i] == m_chrom[best] && m_pos[i] == m_pos[best]) begin
        mask[i] = 1'b1;
        rd = rd + m_reads[i];
        mt = mt + m_meth[i];
        m_pend[i] = 1;
      end
    end
    r.status = ST_SITE;
    r.chrom = m_chrom[best];
    r.pos = m_pos[best];
    r.reads = rd[20] ? '1 : rd[19:0];
    r.meth = mt[19] ? '1 : mt[18:0];
    r.mask = mask;
    return 2;
  endfunction

  // input driver: holds push until the transaction is taken
  always @(posedge clk) begin
    result_t r;
    bit taken;
    int k;
    if (!rst) begin
      taken = 0;
      if (push && !full) begin
        k = merge_refill(drv_item, r);
        if (k == 2) site_q = {site_q, r};
        if (k != 0) useful++;
        in_flight--;
        taken = 1;
        if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
      end
      if (!push || taken) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (refill_q.size() > 0) begin
          drv_item <= refill_q.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result monitor with random stalls
  always @(posedge clk) begin
    result_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (site_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: status %0d", status);
        end else begin
          e = site_q.pop_front();
          if (status != e.status || site_chrom != e.chrom || site_pos != e.pos ||
              total_reads != e.reads || total_meth != e.meth ||
              stream_mask != e.mask || bad_stream != e.bad) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp %0d %0d %h %0d %0d %h %0d act %0d %0d %h %0d %0d %h %0d",
                       e.status, e.chrom, e.pos, e.reads, e.meth, e.mask, e.bad,
                       status, site_chrom, site_pos, total_reads, total_meth,
                       stream_mask, bad_stream);
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        pop_gap = $urandom_range(0, 6);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb_sorted_stream_merge_count_sum_core: errors");
      $finish;
    end
  end

  task automatic send(int id, bit fin, bit nc, int rank, logic [31:0] step,
                      logic [15:0] m, logic [15:0] u);
    item_t it;
    it.id = id[2:0]; it.is_end = fin; it.new_chrom = nc; it.rank = rank[9:0];
    it.step = step; it.meth = m; it.unmeth = u;
    in_flight++;
    refill_q = {refill_q, it};
    wait (in_flight == 0);
  endtask

  // idle point: all results back, then let the core settle
  task automatic drain();
    wait (in_flight == 0 && site_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_active(logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    m_active = v;
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_pending();
    int ids[$];
    for (int i = 0; i < live_streams(); i++)
      if (m_pend[i]) ids = {ids, i};
    if (ids.size() == 0) return -1;
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // mostly in-order refills of pending streams, some noise and broken steps
  task automatic random_run(int count);
    int target;
    int s;
    int r;
    int rank;
    logic [31:0] step;
    logic [15:0] m, u;
    target = useful + count;
    while (useful < target) begin
      r = $urandom_range(0, 99);
      s = pick_pending();
      if (s < 0) return;
      m = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
      u = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 40));
      if (r < 6) begin
        send($urandom_range(0, 7), 0, $urandom_range(0, 1), $urandom_range(0, 1023),
             $urandom, m, u);
      end else if (r < 10) begin
        send(s, 0, 0, 0, 0, m, u);
      end else begin
        step = (r < 13) ? 32'($urandom) : 32'($urandom_range(1, 4));
        if (r < 20 || m_pos[s] > 32'hF000_0000) begin
          rank = m_chrom[s] + (($urandom_range(0, 7) == 0) ? 0 : 1);
          if (rank > 1023) rank = 1023;
          send(s, 0, 1, rank, step, m, u);
        end else begin
          send(s, 0, 0, $urandom_range(0, 1023), step, m, u);
        end
      end
    end
  endtask

  initial begin
    int s;
    merge_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single stream: extremes, saturation, unsorted, ignored id
    set_active(4'd1);
    send(0, 0, 1, 0, 32'hFFFF_FFF0, 16'hFFFF, 16'hFFFF);
    send(0, 0, 0, 0, 32'h20, 16'h0, 16'hFFFF);
    send(0, 0, 0, 0, 32'h1, 16'h1, 16'h1);
    send(0, 0, 0, 0, 32'h0, 16'h1, 16'h1);
    send(3, 0, 1, 5, 32'h5, 16'h1, 16'h1);
    send(0, 0, 1, 1023, 32'h0, 16'h0, 16'h0);
    send(0, 0, 1, 1, 32'h5, 16'h8000, 16'h7FFF);
    set_active(4'd0);
    random_run(60);

    // all eight streams meet at one site with full counts
    set_active(4'd8);
    for (int i = 0; i < NSTR; i++) begin
      s = pick_pending();
      if (s >= 0) send(s, 0, 1, 1022, 32'h7, 16'hFFFF, 16'hFFFF);
    end
    random_run(120);
    set_active(4'd15);
    random_run(100);

    // sender holds off until every result is back
    wait (in_flight == 0 && site_q.size() == 0);
    set_active(4'd3);
    random_run(70);
    set_active(4'd8);
    // keep refilling other streams until stream 7 wants a refill
    while (!m_pend[7]) random_run(1);
    send(7, 1, 0, 0, 0, 0, 0);
    random_run(60);

    // final stretch without idling: end every stream, then a stray refill
    quiet = 1;
    random_run(40);
    s = pick_pending();
    while (s >= 0) begin
      send(s, 1, 0, 0, 0, 0, 0);
      s = pick_pending();
    end
    send(0, 0, 1, 3, 32'h9, 16'h2, 16'h2);
    drain();
    if (errors == 0) begin
      $display("tb_sorted_stream_merge_count_sum_core: clean");
    end else begin
      $display("tb_sorted_stream_merge_count_sum_core: errors");
    end
    $finish;
  end
endmodule
